FILE: hdl/bnf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bnf_pkg
// Shared types and constants of the binary number formatter.
// ----------------------------------------------------------------------------
package bnf_pkg;

    localparam int LEN_W  = 11;
    localparam int TOT_W  = 9;
    localparam int WIDX_W = 5;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_UB    = 8'h42;
    localparam logic [7:0] CH_LB    = 8'h62;

    typedef enum logic [2:0] {
        REG_LEFT_ALIGN   = 3'd0,
        REG_FORCE_PLUS   = 3'd1,
        REG_SPACE_SIGN   = 3'd2,
        REG_ALT_PREFIX   = 3'd3,
        REG_ZERO_FILL    = 3'd4,
        REG_UPPER_PREFIX = 3'd5,
        REG_FIELD_WIDTH  = 3'd6,
        REG_MIN_DIGITS   = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic       left_align;
        logic       force_plus;
        logic       space_sign;
        logic       alt_prefix;
        logic       zero_fill;
        logic       upper_prefix;
        logic [7:0] field_width;
        logic [8:0] min_digits;
    } cfg_t;

    // Request descriptor: text is lead spaces, head, pad, digits, trail spaces.
    typedef struct packed {
        logic [63:0]      src;
        logic             twos;
        logic [4:0][7:0]  head;
        logic [LEN_W-1:0] b1;
        logic [LEN_W-1:0] b2;
        logic [LEN_W-1:0] b3;
        logic [LEN_W-1:0] b4;
        logic [TOT_W-1:0] tot;
    } desc_t;

endpackage
`default_nettype wire

FILE: hdl/binary_number_formatter_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// binary_number_formatter_unit
// Renders a signed 64-bit value as ASCII binary text under printf-style flags.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  in      | in_valid/in_stall   | value[63:0]
//  out     | out_valid/out_stall | chars, byte_count, last_word, total_length
//  cfg     | cfg_we              | cfg_index[2:0], cfg_data[8:0]
//
//  The word generator emits a request as ceil(length/8) words (at least one),
//  one word per cycle while out_stall is low; this output stage sets the rate.
//  Values pass the classifier stages and the queue before the first word.
//  Reset clears control state; registers return to their defaults.
//  Either side may stall; a two-entry queue decouples front and back.
// ----------------------------------------------------------------------------
module binary_number_formatter_unit
    import bnf_pkg::*;
#(
    parameter int OUTPUT_CAP   = 256,
    parameter int DIGIT_BUFFER = 256
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [63:0] value,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      chars,
    output logic [3:0]       byte_count,
    output logic             last_word,
    output logic [8:0]       total_length,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [8:0]  cfg_data
);

    cfg_t  cfg_reg;
    logic  in_ready;
    logic  f_valid, f_ready, b_valid, b_ready;
    desc_t f_data, b_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg            <= '0;
            cfg_reg.min_digits <= 9'h1FF;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_LEFT_ALIGN:   cfg_reg.left_align   <= cfg_data[0];
                REG_FORCE_PLUS:   cfg_reg.force_plus   <= cfg_data[0];
                REG_SPACE_SIGN:   cfg_reg.space_sign   <= cfg_data[0];
                REG_ALT_PREFIX:   cfg_reg.alt_prefix   <= cfg_data[0];
                REG_ZERO_FILL:    cfg_reg.zero_fill    <= cfg_data[0];
                REG_UPPER_PREFIX: cfg_reg.upper_prefix <= cfg_data[0];
                REG_FIELD_WIDTH:  cfg_reg.field_width  <= cfg_data[7:0];
                REG_MIN_DIGITS:   cfg_reg.min_digits   <= cfg_data;
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign in_stall = !in_ready;

    bnf_front #(
        .OUTPUT_CAP   (OUTPUT_CAP),
        .DIGIT_BUFFER (DIGIT_BUFFER)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .value    (value),
        .q_valid  (f_valid),
        .q_ready  (f_ready),
        .q_data   (f_data)
    );

    bnf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_data),
        .rd_valid (b_valid),
        .rd_ready (b_ready),
        .rd_data  (b_data)
    );

    bnf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (b_valid),
        .q_ready      (b_ready),
        .q_data       (b_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .chars        (chars),
        .byte_count   (byte_count),
        .last_word    (last_word),
        .total_length (total_length)
    );

endmodule
`default_nettype wire

FILE: hdl/bnf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bnf_front
// Four-stage classifier: magnitude, digit count and head, padding, bounds.
// ----------------------------------------------------------------------------
module bnf_front
    import bnf_pkg::*;
#(
    parameter int OUTPUT_CAP   = 256,
    parameter int DIGIT_BUFFER = 256
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_t        cfg,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [63:0] value,
    output logic             q_valid,
    input  wire logic        q_ready,
    output desc_t            q_data
);

    localparam int OLIM = (OUTPUT_CAP < 256) ? OUTPUT_CAP : 256;
    localparam logic [LEN_W-1:0] DMAX = LEN_W'(DIGIT_BUFFER - 1);
    localparam logic [LEN_W-1:0] OLIM_L = LEN_W'(OLIM);

    logic s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    // stage 1
    logic [63:0] s1_src_reg, s1_search_reg;
    logic        s1_twos_reg, s1_neg_reg, s1_zero_reg;
    // stage 2
    logic [63:0]     s2_src_reg;
    logic            s2_twos_reg;
    logic [6:0]      s2_nd_reg;
    logic [4:0][7:0] s2_head_reg;
    logic [2:0]      s2_hn_reg;
    // stage 3
    logic [63:0]      s3_src_reg;
    logic             s3_twos_reg;
    logic [4:0][7:0]  s3_head_reg;
    logic [2:0]       s3_hn_reg;
    logic [6:0]       s3_nd_reg;
    logic [LEN_W-1:0] s3_ls_reg, s3_pn_reg, s3_tn_reg;
    // stage 4
    desc_t s4_reg;

    assign rdy4     = !s4_v_reg || q_ready;
    assign rdy3     = !s3_v_reg || rdy4;
    assign rdy2     = !s2_v_reg || rdy3;
    assign rdy1     = !s1_v_reg || rdy2;
    assign in_ready = rdy1;
    assign q_valid  = s4_v_reg;
    assign q_data   = s4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) s1_v_reg <= in_valid;
            if (rdy2) s2_v_reg <= s1_v_reg;
            if (rdy3) s3_v_reg <= s2_v_reg;
            if (rdy4) s4_v_reg <= s3_v_reg;
        end
    end

    // stage 1: form and magnitude
    logic        twos_c, neg_c;
    logic [63:0] mag_c;
    always_comb
    begin
        neg_c  = value[63];
        twos_c = neg_c && !cfg.force_plus && !cfg.space_sign;
        mag_c  = neg_c ? (~value + 64'd1) : value;
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            s1_twos_reg   <= twos_c;
            s1_neg_reg    <= neg_c;
            s1_zero_reg   <= (value == 64'd0);
            s1_src_reg    <= twos_c ? value : mag_c;
            s1_search_reg <= twos_c ? {1'b0, ~value[62:0]} : mag_c;
        end
    end

    // stage 2: highest set bit, digit count, head text
    logic [7:0]      byte_any;
    logic [7:0][2:0] byte_top;
    logic            any_c;
    logic [5:0]      hi_c;
    logic [6:0]      nd_c;
    logic [4:0][7:0] head_c;
    logic [2:0]      hn_c;
    logic [7:0]      sign_c;

    always_comb
    begin
        for (int b = 0; b < 8; b++)
        begin
            byte_any[b] = |s1_search_reg[8*b +: 8];
            byte_top[b] = 3'd0;
            for (int i = 0; i < 8; i++)
            begin
                if (s1_search_reg[8*b + i]) byte_top[b] = 3'(i);
            end
        end
        any_c = 1'b0;
        hi_c  = 6'd0;
        for (int b = 0; b < 8; b++)
        begin
            if (byte_any[b])
            begin
                any_c = 1'b1;
                hi_c  = {3'(b), byte_top[b]};
            end
        end
        if (s1_twos_reg)
            nd_c = any_c ? (7'(hi_c) + 7'd2) : 7'd1;
        else if (any_c)
            nd_c = 7'(hi_c) + 7'd1;
        else
            nd_c = (cfg.min_digits == 9'd0) ? 7'd0 : 7'd1;

        sign_c = 8'd0;
        if (!s1_twos_reg)
        begin
            if (s1_neg_reg)          sign_c = CH_MINUS;
            else if (cfg.force_plus) sign_c = CH_PLUS;
            else if (cfg.space_sign) sign_c = CH_SPACE;
        end
        head_c = '0;
        hn_c   = 3'd0;
        if (sign_c != 8'd0)
        begin
            head_c[hn_c] = sign_c;
            hn_c = hn_c + 3'd1;
        end
        if (cfg.alt_prefix && !s1_zero_reg)
        begin
            head_c[hn_c] = CH_ZERO;
            hn_c = hn_c + 3'd1;
            head_c[hn_c] = cfg.upper_prefix ? CH_UB : CH_LB;
            hn_c = hn_c + 3'd1;
        end
        if (s1_twos_reg)
        begin
            head_c[hn_c] = CH_DOT;
            hn_c = hn_c + 3'd1;
            head_c[hn_c] = CH_DOT;
            hn_c = hn_c + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy2 && s1_v_reg)
        begin
            s2_src_reg  <= s1_src_reg;
            s2_twos_reg <= s1_twos_reg;
            s2_nd_reg   <= nd_c;
            s2_head_reg <= head_c;
            s2_hn_reg   <= hn_c;
        end
    end

    // stage 3: precision and width padding
    logic              prec_en;
    logic signed [LEN_W:0] target_c;
    logic [LEN_W-1:0]  tcl_c, extra_c, bn_c, pad_c;
    logic              zf_c;

    always_comb
    begin
        prec_en  = !cfg.min_digits[8];
        target_c = $signed({4'd0, cfg.min_digits[7:0]})
                   - (s2_twos_reg ? (LEN_W+1)'(2) : (LEN_W+1)'(0));
        if (target_c > $signed({1'b0, DMAX}))
            tcl_c = DMAX;
        else
            tcl_c = target_c[LEN_W-1:0];
        if (prec_en && (target_c > $signed((LEN_W+1)'(s2_nd_reg))))
            extra_c = tcl_c - LEN_W'(s2_nd_reg);
        else
            extra_c = '0;
        bn_c  = LEN_W'(s2_hn_reg) + extra_c + LEN_W'(s2_nd_reg);
        pad_c = (LEN_W'(cfg.field_width) > bn_c) ? (LEN_W'(cfg.field_width) - bn_c) : '0;
        zf_c  = cfg.zero_fill && !prec_en;
    end

    always_ff @(posedge clk)
    begin
        if (rdy3 && s2_v_reg)
        begin
            s3_src_reg  <= s2_src_reg;
            s3_twos_reg <= s2_twos_reg;
            s3_head_reg <= s2_head_reg;
            s3_hn_reg   <= s2_hn_reg;
            s3_nd_reg   <= s2_nd_reg;
            s3_ls_reg   <= (!cfg.left_align && !zf_c) ? pad_c : '0;
            s3_pn_reg   <= extra_c + ((!cfg.left_align && zf_c) ? pad_c : '0);
            s3_tn_reg   <= cfg.left_align ? pad_c : '0;
        end
    end

    // stage 4: segment bounds and capped length
    logic [LEN_W-1:0] b2_c, b3_c, b4_c, end_c;
    always_comb
    begin
        b2_c  = s3_ls_reg + LEN_W'(s3_hn_reg);
        b3_c  = b2_c + s3_pn_reg;
        b4_c  = b3_c + LEN_W'(s3_nd_reg);
        end_c = b4_c + s3_tn_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rdy4 && s3_v_reg)
        begin
            s4_reg.src  <= s3_src_reg;
            s4_reg.twos <= s3_twos_reg;
            s4_reg.head <= s3_head_reg;
            s4_reg.b1   <= s3_ls_reg;
            s4_reg.b2   <= b2_c;
            s4_reg.b3   <= b3_c;
            s4_reg.b4   <= b4_c;
            s4_reg.tot  <= (end_c > OLIM_L) ? TOT_W'(OLIM) : end_c[TOT_W-1:0];
        end
    end

endmodule
`default_nettype wire

FILE: hdl/bnf_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bnf_queue
// Two-entry request queue between classifier and word generator.
// ----------------------------------------------------------------------------
module bnf_queue
    import bnf_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  wr_valid,
    output logic       wr_ready,
    input  wire desc_t wr_data,
    output logic       rd_valid,
    input  wire logic  rd_ready,
    output desc_t      rd_data
);

    desc_t      mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= !wp_reg;
            if (pop)  rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("queue count out of range");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0) |-> !pop)
        else $error("pop from empty queue");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2) && !pop |=> cnt_reg == 2'd2)
        else $error("queue overfilled");
`endif

endmodule
`default_nettype wire

FILE: hdl/bnf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bnf_back
// Word generator: up to eight chars per unstalled cycle into output register.
// ----------------------------------------------------------------------------
module bnf_back
    import bnf_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  q_valid,
    output logic       q_ready,
    input  wire desc_t q_data,
    output logic       out_valid,
    input  wire logic  out_stall,
    output logic [63:0] chars,
    output logic [3:0]  byte_count,
    output logic        last_word,
    output logic [8:0]  total_length
);

    desc_t             cur_reg;
    logic              cur_v_reg;
    logic [WIDX_W-1:0] w_reg;
    logic              out_v_reg;
    logic [63:0]       chars_reg;
    logic [3:0]        cnt_reg;
    logic              last_reg;
    logic [TOT_W-1:0]  tot_reg;

    logic              load;
    logic              done;
    logic [7:0]        base;
    logic [TOT_W-1:0]  rem;
    logic [3:0]        cnt_c;
    logic              last_c;
    logic [63:0]       word_c;

    assign load    = cur_v_reg && (!out_v_reg || !out_stall);
    assign done    = load && last_c;
    assign q_ready = !cur_v_reg || done;

    always_comb
    begin
        logic [7:0]       p;
        logic [LEN_W-1:0] pl, hidx, bpos;
        logic [7:0]       ch;
        base   = {w_reg, 3'b000};
        rem    = cur_reg.tot - TOT_W'(base);
        last_c = (rem <= TOT_W'(8));
        cnt_c  = last_c ? rem[3:0] : 4'd8;
        word_c = '0;
        for (int k = 0; k < 8; k++)
        begin
            p    = base + 8'(k);
            pl   = LEN_W'(p);
            hidx = pl - cur_reg.b1;
            bpos = cur_reg.b4 - LEN_W'(1) - pl;
            if (pl < cur_reg.b1)
                ch = CH_SPACE;
            else if (pl < cur_reg.b2)
                ch = cur_reg.head[hidx[2:0]];
            else if (pl < cur_reg.b3)
                ch = cur_reg.twos ? CH_ONE : CH_ZERO;
            else if (pl < cur_reg.b4)
                ch = cur_reg.src[bpos[5:0]] ? CH_ONE : CH_ZERO;
            else
                ch = CH_SPACE;
            if (4'(k) < cnt_c) word_c[8*k +: 8] = ch;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_v_reg <= 1'b0;
            w_reg     <= '0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (q_valid && q_ready)
            begin
                cur_v_reg <= 1'b1;
                w_reg     <= '0;
            end
            else if (done)
                cur_v_reg <= 1'b0;
            else if (load)
                w_reg <= w_reg + WIDX_W'(1);

            if (load)
                out_v_reg <= 1'b1;
            else if (!out_stall)
                out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_valid && q_ready) cur_reg <= q_data;
        if (load)
        begin
            chars_reg <= word_c;
            cnt_reg   <= cnt_c;
            last_reg  <= last_c;
            tot_reg   <= cur_reg.tot;
        end
    end

    assign out_valid    = out_v_reg;
    assign chars        = chars_reg;
    assign byte_count   = cnt_reg;
    assign last_word    = last_reg;
    assign total_length = tot_reg;

`ifndef NO_ASSERTIONS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg |-> cnt_reg <= 4'd8)
        else $error("byte count above eight");
    a_full_mid: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg && !last_reg |-> cnt_reg == 4'd8)
        else $error("short word before last");
    a_load_needs_req: assert property (@(posedge clk) disable iff (!rst_n)
        !cur_v_reg |=> !out_v_reg || $stable(chars_reg))
        else $error("word produced without request");
`endif

endmodule
`default_nettype wire
